// ----- hdl/mrrc_pkg.sv -----
// Types, codes and constants for the Modbus RTU response checker.
// No dependencies; used by every module in hdl/.
`default_nettype none

package mrrc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CRC    = 2'd1,
        ST_HEADER = 2'd2,
        ST_FAIL   = 2'd3
    } status_t;

    // Input operation codes
    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } op_t;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ADDRESS     = 1'b0;
    localparam logic CFG_EXPECTED_FUNCTION = 1'b1;

    localparam logic [7:0]  SLAVE_ADDRESS_RST     = 8'h01;
    localparam logic [7:0]  EXPECTED_FUNCTION_RST = 8'h03;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame byte positions
    localparam logic [3:0] POS_ADDRESS  = 4'd0;
    localparam logic [3:0] POS_FUNCTION = 4'd1;
    localparam logic [3:0] POS_DATA_HI  = 4'd3;
    localparam logic [3:0] POS_DATA_LO  = 4'd4;
    localparam logic [3:0] CRC_BYTES    = 4'd7;
    localparam logic [3:0] FRAME_LAST   = 4'd8;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] meter_value;
    } out_item_t;

    // Result handed from the frame logic to the output register
    typedef struct packed {
        logic      push;
        out_item_t item;
    } result_t;

    // One byte of CRC-16/Modbus, reflected, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mrrc_frame.sv -----
// Input register and frame state: byte counter, running CRC, header flag, data word.
// Depends on mrrc_pkg.
`default_nettype none

module mrrc_frame (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mrrc_pkg::in_item_t in_data,
    input  wire logic [7:0]        slave_address,
    input  wire logic [7:0]        expected_function,
    input  wire logic              res_ready,
    output mrrc_pkg::result_t      res
);

    logic               item_valid_reg;
    mrrc_pkg::in_item_t item_reg;

    logic [3:0]  byte_count_reg, byte_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic        header_ok_reg, header_ok_next;
    logic [15:0] data_word_reg, data_word_next;
    logic [7:0]  crc_low_byte_reg, crc_low_byte_next;

    logic        is_timeout;
    logic        is_final;
    logic        produces;
    logic        advance;
    logic [15:0] frame_crc_word;
    logic [7:0]  b;

    assign b              = item_reg.rx_byte;
    assign is_timeout     = (item_reg.operation == mrrc_pkg::OP_TIMEOUT);
    assign is_final       = (byte_count_reg >= mrrc_pkg::FRAME_LAST);
    assign produces       = is_timeout || is_final;
    assign advance        = item_valid_reg && (!produces || res_ready);
    assign in_ready       = !item_valid_reg || advance;
    assign frame_crc_word = {b, crc_low_byte_reg};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    // Next frame state and result
    always_comb
    begin
        byte_count_next   = byte_count_reg;
        running_crc_next  = running_crc_reg;
        header_ok_next    = header_ok_reg;
        data_word_next    = data_word_reg;
        crc_low_byte_next = crc_low_byte_reg;
        res.push             = advance && produces;
        res.item.status      = mrrc_pkg::ST_FAIL;
        res.item.meter_value = 16'h0000;

        if (is_timeout || is_final)
        begin
            if (!is_timeout)
            begin
                if (frame_crc_word != running_crc_reg)
                begin
                    res.item.status = mrrc_pkg::ST_CRC;
                end
                else if (!header_ok_reg)
                begin
                    res.item.status = mrrc_pkg::ST_HEADER;
                end
                else
                begin
                    res.item.status      = mrrc_pkg::ST_OK;
                    res.item.meter_value = data_word_reg;
                end
            end
            byte_count_next   = 4'd0;
            running_crc_next  = mrrc_pkg::CRC_INIT;
            header_ok_next    = 1'b1;
            data_word_next    = 16'h0000;
            crc_low_byte_next = 8'h00;
        end
        else if (byte_count_reg == mrrc_pkg::CRC_BYTES)
        begin
            crc_low_byte_next = b;
            byte_count_next   = mrrc_pkg::FRAME_LAST;
        end
        else
        begin
            case (byte_count_reg)
                mrrc_pkg::POS_ADDRESS:
                begin
                    header_ok_next = (b == slave_address);
                end
                mrrc_pkg::POS_FUNCTION:
                begin
                    header_ok_next = header_ok_reg && (b == expected_function);
                end
                mrrc_pkg::POS_DATA_HI:
                begin
                    data_word_next = {b, data_word_reg[7:0]};
                end
                mrrc_pkg::POS_DATA_LO:
                begin
                    data_word_next = {data_word_reg[15:8], b};
                end
                default:
                begin
                    header_ok_next = header_ok_reg;
                end
            endcase
            running_crc_next = mrrc_pkg::crc_feed(running_crc_reg, b);
            byte_count_next  = byte_count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= 4'd0;
            running_crc_reg  <= mrrc_pkg::CRC_INIT;
            header_ok_reg    <= 1'b1;
            data_word_reg    <= 16'h0000;
            crc_low_byte_reg <= 8'h00;
        end
        else if (advance)
        begin
            byte_count_reg   <= byte_count_next;
            running_crc_reg  <= running_crc_next;
            header_ok_reg    <= header_ok_next;
            data_word_reg    <= data_word_next;
            crc_low_byte_reg <= crc_low_byte_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mrrc_out_reg.sv -----
// Output result register with valid/ready handshake.
// Depends on mrrc_pkg.
`default_nettype none

module mrrc_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mrrc_pkg::result_t  res,
    output logic                    res_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mrrc_pkg::out_item_t     out_data
);

    logic                out_valid_reg;
    mrrc_pkg::out_item_t out_data_reg;

    // Free when empty or when the held item leaves this cycle
    assign res_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.push)
        begin
            out_data_reg <= res.item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/modbus_rtu_response_checker.sv -----
// Top level of the Modbus RTU read-response checker: configuration registers,
// frame logic and output register. Depends on mrrc_pkg, mrrc_frame, mrrc_out_reg.
`default_nettype none

// Checks a nine-byte Modbus RTU read-holding-registers response delivered one
// byte per input item (operation 0), or aborts the frame on a receive timeout
// (operation 1). Bytes 0..6 feed a CRC-16/Modbus (init 0xFFFF, poly 0xA001);
// bytes 7 and 8 carry the received CRC, low byte first. The ninth byte yields
// one result: crc mismatch takes priority over a bad header (byte 0 against
// slave_address, byte 1 against expected_function); on success meter_value is
// {byte3, byte4}. A timeout always yields status 3 with meter_value 0 and
// restarts the frame. Rate: one item per cycle unless out_ready stalls the
// output; an item passes an input register and its result is then registered
// in the output register. The per-byte CRC update (eight shift steps
// unrolled) is the longest path. Write slave_address (index 0) and
// expected_function (index 1) only while no frame is in progress.
module modbus_rtu_response_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mrrc_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mrrc_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [7:0]          cfg_wdata
);

    logic [7:0]        slave_address_reg;
    logic [7:0]        expected_function_reg;
    mrrc_pkg::result_t res;
    logic              res_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg     <= mrrc_pkg::SLAVE_ADDRESS_RST;
            expected_function_reg <= mrrc_pkg::EXPECTED_FUNCTION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrrc_pkg::CFG_SLAVE_ADDRESS:
                begin
                    slave_address_reg <= cfg_wdata;
                end
                mrrc_pkg::CFG_EXPECTED_FUNCTION:
                begin
                    expected_function_reg <= cfg_wdata;
                end
                default:
                begin
                    slave_address_reg <= slave_address_reg;
                end
            endcase
        end
    end

    // Frame tracking and result decision
    mrrc_frame u_frame (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_data           (in_data),
        .slave_address     (slave_address_reg),
        .expected_function (expected_function_reg),
        .res_ready         (res_ready),
        .res               (res)
    );

    // Hold each result until the consumer takes it
    mrrc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
